FILE: hdl/mbrc_pkg.sv
`default_nettype none

package mbrc_pkg;

  localparam int MAX_PDU_BYTES_DEF = 253;
  localparam int RESQ_DEPTH        = 4;

  localparam logic [7:0] FN_COILS    = 8'd1;
  localparam logic [7:0] FN_DISCRETE = 8'd2;
  localparam logic [7:0] FN_HOLDING  = 8'd3;
  localparam logic [7:0] FN_INPUT    = 8'd4;

  localparam logic [7:0]  EXPECTED_FUNCTION_RST = 8'd3;
  localparam logic [10:0] EXPECTED_COUNT_RST    = 11'd1;

  typedef enum logic {
    REG_EXPECTED_FUNCTION = 1'b0,
    REG_EXPECTED_COUNT    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_BITS   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    VD_OK        = 2'd0,
    VD_BAD_HEAD  = 2'd2,
    VD_BAD_COUNT = 2'd3
  } verdict_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic [7:0]  item_index;
    status_t     status;
    logic [7:0]  exception_code;
    logic        end_of_run;
  } result_t;

  // results caused by one accepted byte: optional data word, then optional status
  typedef struct packed {
    logic    data_vld;
    result_t data;
    logic    stat_vld;
    result_t stat;
  } res_pair_t;

endpackage

`default_nettype wire

FILE: hdl/mbrc_parse.sv
`default_nettype none

module mbrc_parse #(
  parameter int MAX_PDU_BYTES = mbrc_pkg::MAX_PDU_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [7:0]        expected_function,
  input  wire logic [10:0]       expected_count,
  output mbrc_pkg::res_pair_t    res
);

  logic [7:0]          pos_r, pos_nxt;
  logic [7:0]          decl_r, decl_nxt;
  logic [7:0]          pend_r, pend_nxt;
  mbrc_pkg::verdict_t  verdict_r, verdict_nxt;
  logic [7:0]          cap_r, cap_nxt;
  logic                is_exc_r, is_exc_nxt;

  logic        wr, br;
  logic [11:0] want;
  logic [7:0]  d;
  logic [8:0]  len;

  assign wr = (expected_function == mbrc_pkg::FN_HOLDING) ||
              (expected_function == mbrc_pkg::FN_INPUT);
  assign br = (expected_function == mbrc_pkg::FN_COILS) ||
              (expected_function == mbrc_pkg::FN_DISCRETE);
  // coil count over 2040 gives 256, which no byte count matches
  assign want = wr ? {expected_count, 1'b0}
                   : 12'(({1'b0, expected_count} + 12'd7) >> 3);
  assign d    = pos_r - 8'd2;
  assign len  = {1'b0, pos_r} + 9'd1;

  always_comb begin
    pos_nxt     = pos_r;
    decl_nxt    = decl_r;
    pend_nxt    = pend_r;
    verdict_nxt = verdict_r;
    cap_nxt     = cap_r;
    is_exc_nxt  = is_exc_r;
    res         = '0;

    if (pos_r < 8'(MAX_PDU_BYTES)) begin
      if (pos_r == 8'd0) begin
        if (data_byte[7]) begin
          is_exc_nxt  = 1'b1;
          verdict_nxt = mbrc_pkg::VD_BAD_HEAD;
        end else if (data_byte != expected_function) begin
          verdict_nxt = mbrc_pkg::VD_BAD_HEAD;
        end
      end else if (pos_r == 8'd1) begin
        decl_nxt = data_byte;
        if (is_exc_r) cap_nxt = data_byte;
        if (verdict_r == mbrc_pkg::VD_OK && (wr || br)) begin
          if ({4'd0, data_byte} != want ||
              ({1'b0, data_byte} + 9'd2) > 9'(MAX_PDU_BYTES))
            verdict_nxt = mbrc_pkg::VD_BAD_COUNT;
        end
      end else if (verdict_r == mbrc_pkg::VD_OK && d < decl_r) begin
        if (wr) begin
          if (d[0]) begin
            res.data_vld        = 1'b1;
            res.data.kind       = mbrc_pkg::KIND_WORD;
            res.data.value      = {pend_r, data_byte};
            res.data.item_index = {1'b0, d[7:1]};
          end else begin
            pend_nxt = data_byte;
          end
        end else if (br) begin
          res.data_vld        = 1'b1;
          res.data.kind       = mbrc_pkg::KIND_BITS;
          res.data.value      = {8'd0, data_byte};
          res.data.item_index = d;
        end
      end
    end

    if (last_byte) begin
      res.stat_vld        = 1'b1;
      res.stat.kind       = mbrc_pkg::KIND_STATUS;
      res.stat.end_of_run = 1'b1;
      if (pos_r == 8'd0) begin
        res.stat.status = mbrc_pkg::ST_SHORT;
      end else begin
        if (is_exc_nxt) res.stat.exception_code = cap_nxt;
        if (verdict_nxt == mbrc_pkg::VD_BAD_HEAD)
          res.stat.status = mbrc_pkg::ST_INVALID;
        else if (!(wr || br))
          res.stat.status = mbrc_pkg::ST_OK;
        else if (len < ({1'b0, decl_nxt} + 9'd2))
          res.stat.status = mbrc_pkg::ST_SHORT;
        else if (verdict_nxt == mbrc_pkg::VD_BAD_COUNT)
          res.stat.status = mbrc_pkg::ST_INVALID;
        else
          res.stat.status = mbrc_pkg::ST_OK;
      end
      pos_nxt     = '0;
      decl_nxt    = '0;
      pend_nxt    = '0;
      verdict_nxt = mbrc_pkg::VD_OK;
      cap_nxt     = '0;
      is_exc_nxt  = 1'b0;
    end else begin
      pos_nxt = (pos_r == 8'hFF) ? 8'hFF : pos_r + 8'd1;
    end

    if (!accept) begin
      res.data_vld = 1'b0;
      res.stat_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      decl_r    <= '0;
      pend_r    <= '0;
      verdict_r <= mbrc_pkg::VD_OK;
      cap_r     <= '0;
      is_exc_r  <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      decl_r    <= decl_nxt;
      pend_r    <= pend_nxt;
      verdict_r <= verdict_nxt;
      cap_r     <= cap_nxt;
      is_exc_r  <= is_exc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mbrc_resq.sv
`default_nettype none

module mbrc_resq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mbrc_pkg::res_pair_t res,
  output logic                     room,
  output logic                     out_vld,
  input  wire logic                out_rdy,
  output mbrc_pkg::result_t        out_res
);

  localparam int DEPTH = mbrc_pkg::RESQ_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  mbrc_pkg::result_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  logic              w0, w1, pop;
  mbrc_pkg::result_t e0;
  logic [AW-1:0]     wp1;

  assign w0  = res.data_vld || res.stat_vld;
  assign w1  = res.data_vld && res.stat_vld;
  assign e0  = res.data_vld ? res.data : res.stat;
  assign wp1 = wp_r + AW'(1);
  assign pop = out_vld && out_rdy;

  // space for the two results one byte can cause
  assign room    = cnt_r <= CW'(DEPTH - 2);
  assign out_vld = cnt_r != '0;
  assign out_res = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (w0) mem_r[wp_r] <= e0;
    if (w1) mem_r[wp1]  <= res.stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(w0) + AW'(w1);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(w0) + CW'(w1) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/modbus_response_pdu_checker.sv
// Modbus response PDU checker. Takes one PDU byte per word on the input stream
// (function code first, tlast on the final byte) and checks it against the
// expected function code and quantity written on the cfg port between PDUs.
// Register words (read holding/input) and bit bytes (coil/discrete reads) come
// out as they arrive; a final status word with tlast follows the last byte.
// Data words are emitted before the verdict, so drop them unless the status is
// ok. Each byte is checked combinationally when it is accepted, and a byte is
// accepted every cycle while the result queue has room; a byte that yields both
// a data word and the status fills two queue entries, and the four-entry result
// queue holds in_tready low while fewer than two entries are free.
`default_nettype none

module modbus_response_pdu_checker #(
  parameter int MAX_PDU_BYTES = mbrc_pkg::MAX_PDU_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // value[15:0], item_index[23:16], status[25:24], exception_code[33:26], zero pad
  output logic [39:0]      out_tdata,
  output logic [1:0]       out_tuser,  // result_kind
  output logic             out_tlast,  // end_of_run
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  logic [7:0]  exp_fn_r;
  logic [10:0] exp_cnt_r;

  logic                  accept;
  mbrc_pkg::res_pair_t   res;
  mbrc_pkg::result_t     out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_fn_r  <= mbrc_pkg::EXPECTED_FUNCTION_RST;
      exp_cnt_r <= mbrc_pkg::EXPECTED_COUNT_RST;
    end else if (cfg_we) begin
      unique case (mbrc_pkg::reg_idx_t'(cfg_index))
        mbrc_pkg::REG_EXPECTED_FUNCTION: exp_fn_r  <= cfg_wdata[7:0];
        mbrc_pkg::REG_EXPECTED_COUNT:    exp_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  mbrc_parse #(
    .MAX_PDU_BYTES(MAX_PDU_BYTES)
  ) u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .data_byte         (in_tdata),
    .last_byte         (in_tlast),
    .expected_function (exp_fn_r),
    .expected_count    (exp_cnt_r),
    .res               (res)
  );

  mbrc_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .room    (in_tready),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (out_res)
  );

  assign out_tdata = {6'd0, out_res.exception_code, out_res.status,
                      out_res.item_index, out_res.value};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.end_of_run;

endmodule

`default_nettype wire
